/* rtl/hpm_pkg.sv */
package hpm_pkg;

  // Input transaction: one pixel coordinate.
  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } point_t;

  // Result transaction: mapped coordinate and flags.
  typedef struct packed {
    logic signed [15:0] mapped_x;
    logic signed [15:0] mapped_y;
    logic               inside_res;
    logic               degenerate;
  } result_t;

  // Configuration register indexes.
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t RegCoeffXX   = 3'd0;
  localparam cfg_index_t RegCoeffXY   = 3'd1;
  localparam cfg_index_t RegOffsetX   = 3'd2;
  localparam cfg_index_t RegCoeffYX   = 3'd3;
  localparam cfg_index_t RegCoeffYY   = 3'd4;
  localparam cfg_index_t RegOffsetY   = 3'd5;
  localparam cfg_index_t RegPerspPair = 3'd6;
  localparam cfg_index_t RegPerspConst = 3'd7;

  // Datapath widths: products are 48 bits, sums 49 bits, dividend is the
  // magnitude scaled by 2^14, and 16 quotient bits are resolved.
  localparam int ProdW = 48;
  localparam int NumW  = 49;
  localparam int RemW  = NumW + 14;
  localparam int QuoW  = 16;
  localparam int CmpW  = RemW + 2;

  // One entry of the divider pipeline, carrying both axes.
  typedef struct packed {
    logic [RemW-1:0] r_x;
    logic [RemW-1:0] r_y;
    logic [NumW-1:0] d;
    logic [QuoW-1:0] q_x;
    logic [QuoW-1:0] q_y;
    logic            neg_x;
    logic            neg_y;
    logic            ovf_x;
    logic            ovf_y;
    logic            deg;
  } div_t;

endpackage

/* rtl/homography_point_map.sv */
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------
// point     | in        | start_i, busy_o        | point_i (point_x, point_y)
// result    | out       | done_o (one cycle)     | result_o (mapped, flags)
// config    | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One point is accepted every cycle; busy_o stays low and cfg_ready_o high.
// Pipeline stages: input register, multiply, sum, sign and range check,
// sixteen restoring division stages (one quotient bit each), rounding.
// The sixteen-stage divider sets the depth; throughput is one per clock.
// Reset clears the valid bits and loads the identity homography.
// The receiver cannot stall, so results leave on done_o without holding.
module homography_point_map #(
  parameter int SRC_WIDTH  = 1024,
  parameter int SRC_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  hpm_pkg::point_t     point_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  hpm_pkg::cfg_index_t cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output logic                done_o,
  output hpm_pkg::result_t    result_o
);
  import hpm_pkg::*;

  logic signed [31:0] h00_q, h01_q, h02_q, h10_q, h11_q, h12_q, h22_q;
  logic        [63:0] hpair_q;
  logic signed [31:0] h20, h21;

  logic                    in_vld_q;
  point_t                  in_q;
  logic                    prod_vld_q;
  logic signed [ProdW-1:0] p_xx_q, p_xy_q, p_yx_q, p_yy_q, p_zx_q, p_zy_q;
  logic                    sum_vld_q;
  logic signed [NumW-1:0]  nx_q, ny_q, z_q;
  logic [NumW-1:0]         abs_x, abs_y, abs_z;
  logic [CmpW-1:0]         lim;
  div_t                    div_q [QuoW+1];
  logic [QuoW:0]           div_vld_q;
  logic                    done_q;
  result_t                 res_q;
  logic [15:0]             mx, my;
  logic                    sat_x, sat_y, pos_x, pos_y, in_x, in_y;

  // Round to nearest with ties to even, then clamp to 16-bit signed.
  function automatic logic [16:0] round_sat(input logic [RemW-1:0] r,
                                            input logic [NumW-1:0] d,
                                            input logic [QuoW-1:0] q,
                                            input logic neg, input logic ovf);
    logic [RemW:0] twice;
    logic [RemW:0] dx;
    logic [16:0]   qr;
    logic          sat;
    logic [15:0]   v;
    twice = {r, 1'b0};
    dx    = (RemW+1)'(d);
    qr    = {1'b0, q};
    if (twice > dx || (twice == dx && q[0])) begin
      qr = qr + 17'd1;
    end
    sat = ovf || (neg ? (qr > 17'd32768) : (qr > 17'd32767));
    if (sat) begin
      v = neg ? 16'h8000 : 16'h7fff;
    end else begin
      v = neg ? 16'(-qr) : qr[15:0];
    end
    return {sat, v};
  endfunction

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign h20         = hpair_q[63:32];
  assign h21         = hpair_q[31:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h00_q   <= 32'sd65536;
      h01_q   <= '0;
      h02_q   <= '0;
      h10_q   <= '0;
      h11_q   <= 32'sd65536;
      h12_q   <= '0;
      hpair_q <= '0;
      h22_q   <= 32'sd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCoeffXX:    h00_q   <= cfg_data_i[31:0];
        RegCoeffXY:    h01_q   <= cfg_data_i[31:0];
        RegOffsetX:    h02_q   <= cfg_data_i[31:0];
        RegCoeffYX:    h10_q   <= cfg_data_i[31:0];
        RegCoeffYY:    h11_q   <= cfg_data_i[31:0];
        RegOffsetY:    h12_q   <= cfg_data_i[31:0];
        RegPerspPair:  hpair_q <= cfg_data_i;
        RegPerspConst: h22_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Valid bits for the front stages, the divider and the output strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      sum_vld_q  <= 1'b0;
      div_vld_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      in_vld_q   <= start_i;
      prod_vld_q <= in_vld_q;
      sum_vld_q  <= prod_vld_q;
      div_vld_q  <= {div_vld_q[QuoW-1:0], sum_vld_q};
      done_q     <= div_vld_q[QuoW];
    end
  end

  // Input register, then the six products.
  always_ff @(posedge clk_i) begin
    in_q   <= point_i;
    p_xx_q <= ProdW'(h00_q * in_q.point_x);
    p_xy_q <= ProdW'(h01_q * in_q.point_y);
    p_yx_q <= ProdW'(h10_q * in_q.point_x);
    p_yy_q <= ProdW'(h11_q * in_q.point_y);
    p_zx_q <= ProdW'(h20 * in_q.point_x);
    p_zy_q <= ProdW'(h21 * in_q.point_y);
  end

  // Numerators in Q.16 and divisor in Q.30.
  always_ff @(posedge clk_i) begin
    nx_q <= NumW'(p_xx_q) + NumW'(p_xy_q) + NumW'(h02_q);
    ny_q <= NumW'(p_yx_q) + NumW'(p_yy_q) + NumW'(h12_q);
    z_q  <= NumW'(p_zx_q) + NumW'(p_zy_q) + (NumW'(h22_q) <<< 14);
  end

  // Magnitudes, signs and the check for quotients of 2^16 or more.
  assign abs_x = nx_q[NumW-1] ? NumW'(-nx_q) : NumW'(nx_q);
  assign abs_y = ny_q[NumW-1] ? NumW'(-ny_q) : NumW'(ny_q);
  assign abs_z = z_q[NumW-1]  ? NumW'(-z_q)  : NumW'(z_q);
  assign lim   = CmpW'(abs_z) << QuoW;

  always_ff @(posedge clk_i) begin
    div_q[0].r_x   <= {abs_x, 14'd0};
    div_q[0].r_y   <= {abs_y, 14'd0};
    div_q[0].d     <= abs_z;
    div_q[0].q_x   <= '0;
    div_q[0].q_y   <= '0;
    div_q[0].neg_x <= nx_q[NumW-1] ^ z_q[NumW-1];
    div_q[0].neg_y <= ny_q[NumW-1] ^ z_q[NumW-1];
    div_q[0].ovf_x <= CmpW'({abs_x, 14'd0}) >= lim;
    div_q[0].ovf_y <= CmpW'({abs_y, 14'd0}) >= lim;
    div_q[0].deg   <= (z_q == '0);
  end

  // Restoring divider: each stage resolves one quotient bit, MSB first.
  for (genvar i = 0; i < QuoW; i++) begin : g_div
    localparam int Bit = QuoW - 1 - i;
    logic [CmpW-1:0] dsh, rx, ry;
    div_t            stage_d;

    always_comb begin
      stage_d = div_q[i];
      dsh     = CmpW'(div_q[i].d) << Bit;
      rx      = CmpW'(div_q[i].r_x);
      ry      = CmpW'(div_q[i].r_y);
      if (rx >= dsh) begin
        stage_d.r_x      = RemW'(rx - dsh);
        stage_d.q_x[Bit] = 1'b1;
      end
      if (ry >= dsh) begin
        stage_d.r_y      = RemW'(ry - dsh);
        stage_d.q_y[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[i+1] <= stage_d;
    end
  end

  // Rounding, saturation and the frame test.
  assign {sat_x, mx} = round_sat(div_q[QuoW].r_x, div_q[QuoW].d, div_q[QuoW].q_x,
                                 div_q[QuoW].neg_x, div_q[QuoW].ovf_x);
  assign {sat_y, my} = round_sat(div_q[QuoW].r_y, div_q[QuoW].d, div_q[QuoW].q_y,
                                 div_q[QuoW].neg_y, div_q[QuoW].ovf_y);
  assign pos_x = !mx[15];
  assign pos_y = !my[15];
  assign in_x  = pos_x && (mx < 16'(SRC_WIDTH));
  assign in_y  = pos_y && (my < 16'(SRC_HEIGHT));

  always_ff @(posedge clk_i) begin
    if (div_q[QuoW].deg) begin
      res_q.mapped_x   <= '0;
      res_q.mapped_y   <= '0;
      res_q.inside_res <= 1'b0;
      res_q.degenerate <= 1'b1;
    end else begin
      res_q.mapped_x   <= mx;
      res_q.mapped_y   <= my;
      res_q.inside_res <= !sat_x && !sat_y && in_x && in_y;
      res_q.degenerate <= 1'b0;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // A degenerate result carries zero coordinates and is never inside.
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.degenerate |->
      result_o.mapped_x == '0 && result_o.mapped_y == '0 && !result_o.inside_res)
    else $error("degenerate result with nonzero payload");

  // An inside result lies within the source frame.
  a_inside_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.inside_res |->
      !result_o.mapped_x[15] && !result_o.mapped_y[15] &&
      result_o.mapped_x < 16'(SRC_WIDTH) && result_o.mapped_y < 16'(SRC_HEIGHT))
    else $error("inside flag set outside the frame");

  // Every accepted point produces exactly one result after the pipeline depth.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> ##(QuoW+4) done_o)
    else $error("accepted point lost in pipeline");

  // An overflowed quotient always leaves the frame.
  a_ovf_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld_q[QuoW] && (div_q[QuoW].ovf_x || div_q[QuoW].ovf_y) |=> !result_o.inside_res)
    else $error("overflowed quotient reported inside");

endmodule
